>>> sv/olt_pkg.sv
package olt_pkg;

    localparam int OP_W    = 3;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 6;
    localparam int CAP_W   = 6;
    localparam int IN_DW   = 40;
    localparam int OUT_DW  = 56;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT_AT     = 3'd0,
        OP_INSERT_SORTED = 3'd1,
        OP_ERASE_AT      = 3'd2,
        OP_REMOVE_ALL    = 3'd3,
        OP_GET           = 3'd4,
        OP_SET           = 3'd5,
        OP_FIND          = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_OUT
    } t_state;

    // what a cell loads on the next edge
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_UP,
        CMD_DOWN,
        CMD_LOAD
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      cmp;
    } t_cell_ctl;

    typedef struct packed {
        logic [CNT_W-1:0] sz;
        logic [CNT_W-1:0] rc;
        logic [VAL_W-1:0] rd;
        logic [IDX_W-1:0] idx;
        logic             ok;
    } t_result;

endpackage

>>> sv/olt_cell.sv
module olt_cell (
    input  logic                      i_clk,
    input  olt_pkg::t_cell_ctl        i_ctl,
    input  logic [olt_pkg::VAL_W-1:0] i_val,
    input  logic [olt_pkg::VAL_W-1:0] i_cmp_val,
    input  logic [olt_pkg::VAL_W-1:0] i_lower,
    input  logic [olt_pkg::VAL_W-1:0] i_upper,
    output logic [olt_pkg::VAL_W-1:0] o_data,
    output logic                      o_eq,
    output logic                      o_le
);
    import olt_pkg::*;

    logic [VAL_W-1:0] r_data;
    logic             r_eq;
    logic             r_le;

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_UP:   r_data <= i_lower;
            CMD_DOWN: r_data <= i_upper;
            CMD_LOAD: r_data <= i_val;
            default:  r_data <= r_data;
        endcase
        if (i_ctl.cmp) begin
            r_eq <= (i_cmp_val == r_data);
            r_le <= (i_cmp_val <= r_data);
        end
    end

    assign o_data = r_data;
    assign o_eq   = r_eq;
    assign o_le   = r_le;

endmodule

>>> sv/ordered_list_table.sv
// each accepted word goes through the compare step of the cell row (flags registered
//   in each cell) and then the shift/update step; remove_all repeats both steps for
//   each matching entry; a new word is taken only in idle, after the result is loaded
//   into the output register, which waits while the output register is still full
// reset: synchronous active low, clears the size, sets capacity to 32, drops the
//   output valid; entry contents are not cleared
module ordered_list_table #(
    parameter int DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [olt_pkg::CAP_W-1:0]  i_cfg_wr_data,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // pos, value, zero pad
    input  logic [olt_pkg::IN_DW-1:0]  i_s_tdata,
    // op
    input  logic [olt_pkg::OP_W-1:0]   i_s_tuser,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // ok, index, read_value, removed_count, list_size, zero pad
    output logic [olt_pkg::OUT_DW-1:0] o_m_tdata
);
    import olt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > 6) ? CW : 6;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_val;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_rem, n_rem;
    logic [CAP_W-1:0]  r_cap;
    t_result           r_res, n_res;
    t_result           r_out;
    logic              r_ovalid;

    logic              w_accept;
    logic              w_out_free;
    logic              w_done;
    logic              w_load_out;
    logic              w_cmp;
    logic [VAL_W-1:0]  w_cmp_val;

    logic [VAL_W-1:0]  w_data [DEPTH];
    logic [DEPTH-1:0]  w_eq, w_le, w_valid;
    logic [DEPTH-1:0]  w_sel, w_low, w_ge, w_at;
    logic              w_any;
    logic [WW-1:0]     w_enc, w_p, w_pos_w, w_cnt_w, w_cap_w, w_eff_w, w_sort_w;
    logic [WW-1:0]     w_ncnt_w, w_rem_w;
    logic              w_full;
    logic [VAL_W-1:0]  w_rd;
    t_cell_cmd         w_cmd [DEPTH];

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_cmp      = w_accept || (r_state == S_CMP);
    assign w_cmp_val  = (r_state == S_IDLE) ? i_s_tdata[POS_W +: VAL_W] : r_val;

    // cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        olt_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     ({w_cmd[g], w_cmp}),
            .i_val     (r_val),
            .i_cmp_val (w_cmp_val),
            .i_lower   (w_data[(g > 0) ? g - 1 : g]),
            .i_upper   (w_data[(g < DEPTH - 1) ? g + 1 : g]),
            .o_data    (w_data[g]),
            .o_eq      (w_eq[g]),
            .o_le      (w_le[g])
        );
    end

    // position decode
    assign w_pos_w = WW'(r_pos);
    assign w_cnt_w = WW'(r_count);
    assign w_cap_w = WW'(r_cap);
    assign w_eff_w = (w_cap_w < WW'(DEPTH)) ? w_cap_w : WW'(DEPTH);
    assign w_full  = (w_cnt_w >= w_eff_w);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_valid[i] = (WW'(i) < w_cnt_w);
        end
    end

    assign w_sel = ((r_op == OP_INSERT_SORTED) ? w_le : w_eq) & w_valid;
    assign w_low = w_sel & (~w_sel + DEPTH'(1));
    assign w_any = |w_sel;

    always_comb begin
        w_enc = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_enc = w_enc | (w_low[i] ? WW'(i) : '0);
        end
    end

    assign w_sort_w = w_any ? w_enc : w_cnt_w;

    always_comb begin
        case (r_op)
            OP_INSERT_SORTED: w_p = w_sort_w;
            OP_REMOVE_ALL:    w_p = w_enc;
            default:          w_p = w_pos_w;
        endcase
    end

    always_comb begin
        w_rd = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_ge[i] = (WW'(i) >= w_p);
            w_at[i] = (WW'(i) == w_p);
            w_rd    = w_rd | (w_at[i] ? w_data[i] : '0);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_CMP:  n_state = S_EXEC;
            S_EXEC: begin
                if (!w_done)         n_state = S_CMP;
                else if (w_out_free) n_state = S_IDLE;
                else                 n_state = S_OUT;
            end
            S_OUT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // cell commands and result
    always_comb begin
        n_count = r_count;
        n_rem   = r_rem;
        n_res   = '0;
        w_done  = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
            w_cmd[i] = CMD_HOLD;
        end
        unique case (r_state)
            S_EXEC: begin
                case (r_op)
                    OP_INSERT_AT, OP_INSERT_SORTED: begin
                        if (!w_full && (w_p <= w_cnt_w)) begin
                            n_res.ok = 1'b1;
                            n_count  = r_count + CW'(1);
                            for (int i = 0; i < DEPTH; i++) begin
                                if (w_at[i])      w_cmd[i] = CMD_LOAD;
                                else if (w_ge[i]) w_cmd[i] = CMD_UP;
                            end
                            if (r_op == OP_INSERT_SORTED) n_res.idx = w_sort_w[IDX_W-1:0];
                        end
                    end
                    OP_ERASE_AT: begin
                        if (w_pos_w < w_cnt_w) begin
                            n_res.ok = 1'b1;
                            n_count  = r_count - CW'(1);
                            for (int i = 0; i < DEPTH; i++) begin
                                if (w_ge[i]) w_cmd[i] = CMD_DOWN;
                            end
                        end
                    end
                    OP_REMOVE_ALL: begin
                        // drop the lowest match, then compare again
                        if (w_any) begin
                            w_done  = 1'b0;
                            n_count = r_count - CW'(1);
                            n_rem   = r_rem + CW'(1);
                            for (int i = 0; i < DEPTH; i++) begin
                                if (w_ge[i]) w_cmd[i] = CMD_DOWN;
                            end
                        end else begin
                            n_res.ok = 1'b1;
                            n_res.rc = w_rem_w[CNT_W-1:0];
                        end
                    end
                    OP_GET: begin
                        if (w_pos_w < w_cnt_w) begin
                            n_res.ok = 1'b1;
                            n_res.rd = w_rd;
                        end
                    end
                    OP_SET: begin
                        if (w_pos_w < w_cnt_w) begin
                            n_res.ok = 1'b1;
                            for (int i = 0; i < DEPTH; i++) begin
                                if (w_at[i]) w_cmd[i] = CMD_LOAD;
                            end
                        end
                    end
                    OP_FIND: begin
                        if (w_any) begin
                            n_res.ok  = 1'b1;
                            n_res.idx = w_enc[IDX_W-1:0];
                        end
                    end
                    default: n_res.ok = 1'b0;
                endcase
                n_res.sz = w_ncnt_w[CNT_W-1:0];
            end
            default: w_done = 1'b0;
        endcase
    end

    assign w_ncnt_w = WW'(n_count);
    assign w_rem_w  = WW'(r_rem);

    assign w_load_out = w_out_free &&
                        (((r_state == S_EXEC) && w_done) || (r_state == S_OUT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cap    <= CAP_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_wr_en) r_cap <= i_cfg_wr_data;
            if (w_load_out)      r_ovalid <= 1'b1;
            else if (i_m_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_s_tuser;
            r_pos <= i_s_tdata[POS_W-1:0];
            r_val <= i_s_tdata[POS_W +: VAL_W];
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
        if (r_state == S_EXEC) r_res <= n_res;
        if (w_load_out) r_out <= (r_state == S_EXEC) ? n_res : r_res;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {(OUT_DW - $bits(t_result))'(0), r_out};

endmodule
